// ===== design/ibios_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Bucketed I/O statistics package
// Shared types and constants for the interval bucketed statistics core.
// ----------------------------------------------------------------------------
package ibios_pkg;

    localparam logic [1:0] CMD_READ    = 2'd0;
    localparam logic [1:0] CMD_WRITE   = 2'd1;
    localparam logic [1:0] CMD_READOUT = 2'd2;
    localparam logic [1:0] CMD_NONE    = 2'd3;

    localparam logic [0:0] CFG_INTERVAL = 1'd0;
    localparam logic [0:0] CFG_LIMIT    = 1'd1;

    localparam logic [47:0] INTERVAL_RESET = 48'd1000000;
    localparam logic [4:0]  LIMIT_RESET    = 5'd16;

    // Part of one bucket: statistics for one direction.
    typedef struct packed {
        logic [31:0] count;
        logic [63:0] dur_total;
        logic [47:0] dur_peak;
        logic [63:0] byte_total;
    } t_dir_stats;

    typedef struct packed {
        logic [47:0] stamp;
        t_dir_stats  rd;
        t_dir_stats  wr;
    } t_bucket;

    function automatic logic [63:0] sat_add_s(input logic [63:0] a, input logic [63:0] b);
        logic [63:0] r;
        r = a + b;
        if (a[63] == b[63] && r[63] != a[63]) begin
            r = a[63] ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
        end
        return r;
    endfunction

    function automatic logic [63:0] sat_add_u(input logic [63:0] a, input logic [63:0] b);
        logic [64:0] r;
        r = {1'b0, a} + {1'b0, b};
        return r[64] ? {64{1'b1}} : r[63:0];
    endfunction

endpackage
`default_nettype wire

// ===== design/ibios_update.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Bucket update
// Folds one access into one direction's statistics of a bucket or a fresh one.
// ----------------------------------------------------------------------------
module ibios_update
    import ibios_pkg::*;
(
    input  wire logic        i_fresh,
    input  wire t_bucket     i_old,
    input  wire logic        i_write,
    input  wire logic [47:0] i_start,
    input  wire logic [47:0] i_stop,
    input  wire logic [31:0] i_size,
    output t_bucket          o_new
);
    t_bucket    base;
    t_dir_stats d;
    t_dir_stats u;
    logic        neg;
    logic [47:0] dur;

    always_comb begin
        base = i_fresh ? '0 : i_old;
        if (i_fresh) begin
            base.stamp = i_stop;
        end
        d   = i_write ? base.wr : base.rd;
        neg = i_stop < i_start;
        dur = i_stop - i_start;
        u = d;
        if (!neg && dur > d.dur_peak) begin
            u.dur_peak = dur;
        end
        u.dur_total  = sat_add_s(d.dur_total, {{16{neg}}, dur});
        u.byte_total = sat_add_u(d.byte_total, {32'd0, i_size});
        if (d.count != 32'hFFFF_FFFF) begin
            u.count = d.count + 32'd1;
        end
        o_new = base;
        if (i_write) begin
            o_new.wr = u;
        end else begin
            o_new.rd = u;
        end
    end
endmodule
`default_nettype wire

// ===== design/interval_bucketed_io_stats_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Interval bucketed I/O statistics core
// Ring of time-interval buckets of read and write statistics in one memory.
// ----------------------------------------------------------------------------
// After a record word is accepted the input stays stalled while the core reads
// the newest bucket from the bucket memory (RREAD), decides whether a new
// bucket opens and writes the updated bucket back (RMOD), and passes through
// WAIT before the next word is taken, so a new record word is taken only after
// the last one is written back. A readout word streams every live bucket,
// oldest first, with last_bucket on the newest one; the next bucket is loaded
// only once the previous output word has left, and the input stays stalled
// until the newest bucket is loaded, longer while the output is stalled.
// After reset a clearing pass zeroes every memory entry before the first word is taken.
module interval_bucketed_io_stats_core
    import ibios_pkg::*;
#(
    parameter int DEPTH = 16
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [0:0]  i_cfg_index,
    input  wire logic [47:0] i_cfg_data,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [1:0]  i_command,
    input  wire logic [47:0] i_start_time,
    input  wire logic [47:0] i_stop_time,
    input  wire logic [31:0] i_access_size,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [47:0]      o_bucket_timestamp,
    output logic [31:0]      o_read_count,
    output logic signed [63:0] o_read_sum_time,
    output logic [47:0]      o_read_max_time,
    output logic [63:0]      o_read_sum_size,
    output logic [31:0]      o_write_count,
    output logic signed [63:0] o_write_sum_time,
    output logic [47:0]      o_write_max_time,
    output logic [63:0]      o_write_sum_size,
    output logic             o_last_bucket
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    localparam logic [2:0] ST_CLEAR = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_RREAD = 3'd2;
    localparam logic [2:0] ST_RMOD  = 3'd3;
    localparam logic [2:0] ST_OUT   = 3'd4;
    localparam logic [2:0] ST_WAIT  = 3'd5;

    t_bucket r_mem [DEPTH];
    t_bucket r_rdata;

    logic [2:0]    r_state, n_state;
    logic [47:0]   r_interval;
    logic [4:0]    r_limit;
    logic [AW-1:0] r_oldest, n_oldest;
    logic [CW-1:0] r_total, n_total;
    logic [CW-1:0] r_k, n_k;
    logic [1:0]    r_cmd;
    logic [47:0]   r_start, r_stop;
    logic [31:0]   r_size;
    logic          r_ovalid, n_ovalid;
    logic          r_olast, n_olast;
    t_bucket       r_obuf;
    logic          r_load;

    logic          mem_we;
    logic [AW-1:0] mem_waddr, mem_raddr;
    t_bucket       mem_wdata, upd;
    logic          due, fresh;
    logic [CW-1:0] lim;
    logic [47:0]   ts;
    logic          out_free;

    function automatic logic [AW-1:0] slot(input logic [AW-1:0] base, input logic [CW-1:0] k);
        logic [CW:0] s;
        s = {{(CW + 1 - AW){1'b0}}, base} + {1'b0, k};
        if (s >= (CW + 1)'(DEPTH)) begin
            s = s - (CW + 1)'(DEPTH);
        end
        return s[AW-1:0];
    endfunction

    always_comb begin
        lim = (r_limit == 5'd0) ? CW'(1) :
              ({2'b0, r_limit} > 7'(DEPTH)) ? CW'(DEPTH) : CW'(r_limit);
        ts  = r_rdata.stamp;
        due = (r_stop > ts) && ((r_stop - ts) > r_interval);
    end

    ibios_update u_update (
        .i_fresh (fresh),
        .i_old   (r_rdata),
        .i_write (r_cmd == CMD_WRITE),
        .i_start (r_start),
        .i_stop  (r_stop),
        .i_size  (r_size),
        .o_new   (upd)
    );

    assign out_free = !r_ovalid || !i_stall;
    assign o_stall  = (r_state != ST_IDLE);

    always_comb begin
        n_state   = r_state;
        n_oldest  = r_oldest;
        n_total   = r_total;
        n_k       = r_k;
        n_ovalid  = r_ovalid && i_stall;
        n_olast   = r_olast;
        mem_we    = 1'b0;
        mem_waddr = slot(r_oldest, r_total - CW'(1));
        mem_wdata = upd;
        mem_raddr = slot(r_oldest, r_total - CW'(1));
        fresh     = due;
        case (r_state)
            ST_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = r_k[AW-1:0];
                mem_wdata = '0;
                n_k       = r_k + CW'(1);
                if (r_k == CW'(DEPTH - 1)) begin
                    n_state = ST_IDLE;
                    n_k     = '0;
                end
            end
            ST_IDLE: begin
                if (i_valid) begin
                    case (i_command)
                        CMD_READ, CMD_WRITE: n_state = ST_RREAD;
                        CMD_READOUT: begin
                            n_state = ST_OUT;
                            n_k     = '0;
                        end
                        default: n_state = ST_IDLE;
                    endcase
                end
            end
            ST_RREAD: begin
                n_state = ST_RMOD;
            end
            ST_RMOD: begin
                mem_we = 1'b1;
                if (due) begin
                    if (r_total >= lim) begin
                        n_oldest  = slot(r_oldest, CW'(1));
                        mem_waddr = slot(r_oldest, r_total);
                    end else begin
                        mem_waddr = slot(r_oldest, r_total);
                        n_total   = r_total + CW'(1);
                    end
                end
                n_state = ST_WAIT;
            end
            ST_WAIT: begin
                n_state = ST_IDLE;
            end
            ST_OUT: begin
                mem_raddr = slot(r_oldest, r_k);
                if (out_free && !r_load) begin
                    n_k = r_k + CW'(1);
                    if (r_k + CW'(1) == r_total) begin
                        n_state = ST_WAIT;
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
        if (r_load) begin
            n_ovalid = 1'b1;
            n_olast  = (r_k == r_total);
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        r_rdata <= r_mem[mem_raddr];
        if (r_load) begin
            r_obuf <= r_rdata;
        end
        if (r_state == ST_IDLE && i_valid) begin
            r_cmd   <= i_command;
            r_start <= i_start_time;
            r_stop  <= i_stop_time;
            r_size  <= i_access_size;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_CLEAR;
            r_interval <= INTERVAL_RESET;
            r_limit    <= LIMIT_RESET;
            r_oldest   <= '0;
            r_total    <= CW'(1);
            r_k        <= '0;
            r_ovalid   <= 1'b0;
            r_olast    <= 1'b0;
            r_load     <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_oldest <= n_oldest;
            r_total  <= n_total;
            r_k      <= n_k;
            r_ovalid <= n_ovalid;
            r_olast  <= n_olast;
            r_load   <= (r_state == ST_OUT) && out_free && !r_load;
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_INTERVAL: r_interval <= i_cfg_data;
                    CFG_LIMIT:    r_limit    <= i_cfg_data[4:0];
                    default:      r_limit    <= r_limit;
                endcase
            end
        end
    end

    assign o_valid            = r_ovalid;
    assign o_bucket_timestamp = r_obuf.stamp;
    assign o_read_count       = r_obuf.rd.count;
    assign o_read_sum_time    = r_obuf.rd.dur_total;
    assign o_read_max_time    = r_obuf.rd.dur_peak;
    assign o_read_sum_size    = r_obuf.rd.byte_total;
    assign o_write_count      = r_obuf.wr.count;
    assign o_write_sum_time   = r_obuf.wr.dur_total;
    assign o_write_max_time   = r_obuf.wr.dur_peak;
    assign o_write_sum_size   = r_obuf.wr.byte_total;
    assign o_last_bucket      = r_olast;

`ifndef SYNTHESIS
    a_total_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_total != '0) && (r_total <= CW'(DEPTH)))
        else $error("bucket count out of range");
    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_load |-> !r_ovalid)
        else $error("output overwritten");
    a_rmod_from_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_RMOD) |-> $past(r_state) == ST_RREAD)
        else $error("modify without read");
`endif

endmodule
`default_nettype wire

// ===== verif/interval_bucketed_io_stats_core_checker.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Bucketed I/O statistics checker
// Watches the input, output and register ports of the statistics core, keeps
// its own ring of buckets, predicts every readout word and compares it field
// by field with the word the core returns.
// ----------------------------------------------------------------------------
module interval_bucketed_io_stats_core_checker
    import ibios_pkg::*;
#(
    parameter int DEPTH = 16
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_cfg_we,
    input  wire logic [0:0]    i_cfg_index,
    input  wire logic [47:0]   i_cfg_data,
    input  wire logic          i_valid,
    input  wire logic          i_stall_in,
    input  wire logic [1:0]    i_command,
    input  wire logic [47:0]   i_start_time,
    input  wire logic [47:0]   i_stop_time,
    input  wire logic [31:0]   i_access_size,
    input  wire logic          i_out_valid,
    input  wire logic          i_stall_out,
    input  wire logic [47:0]   i_bucket_timestamp,
    input  wire logic [31:0]   i_read_count,
    input  wire logic [63:0]   i_read_sum_time,
    input  wire logic [47:0]   i_read_max_time,
    input  wire logic [63:0]   i_read_sum_size,
    input  wire logic [31:0]   i_write_count,
    input  wire logic [63:0]   i_write_sum_time,
    input  wire logic [47:0]   i_write_max_time,
    input  wire logic [63:0]   i_write_sum_size,
    input  wire logic          i_last_bucket,
    output int                 o_fail_count,
    output int                 o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    t_bucket     ring [DEPTH];
    int          oldest;
    int          live;
    logic [47:0] interval_us;
    logic [4:0]  limit_reg;

    t_bucket     expected_buckets [$];
    logic        expected_last [$];

    function automatic t_dir_stats account(input t_dir_stats st, input logic [47:0] start,
                                           input logic [47:0] stop, input logic [31:0] size);
        t_dir_stats  r;
        logic [63:0] dur;
        logic [64:0] ssum;
        logic [64:0] usum;
        r = st;
        dur = {16'd0, stop} - {16'd0, start};
        if (stop >= start && {16'd0, stop - start} > {16'd0, r.dur_peak}) begin
            r.dur_peak = stop - start;
        end
        ssum = {r.dur_total[63], r.dur_total} + {dur[63], dur};
        if (ssum[64] != ssum[63]) begin
            r.dur_total = ssum[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
        end else begin
            r.dur_total = ssum[63:0];
        end
        usum = {1'b0, r.byte_total} + {33'd0, size};
        r.byte_total = usum[64] ? {64{1'b1}} : usum[63:0];
        if (r.count != {32{1'b1}}) begin
            r.count = r.count + 32'd1;
        end
        return r;
    endfunction

    task automatic apply_word();
        int          s;
        int          lim;
        logic [47:0] newest;
        if (i_command == CMD_READ || i_command == CMD_WRITE) begin
            newest = ring[(oldest + live - 1) % DEPTH].stamp;
            if (i_stop_time > newest && (i_stop_time - newest) > interval_us) begin
                lim = int'(limit_reg);
                if (lim < 1) begin
                    lim = 1;
                end
                if (lim > DEPTH) begin
                    lim = DEPTH;
                end
                if (live + 1 > lim) begin
                    oldest = (oldest + 1) % DEPTH;
                    live = live - 1;
                end
                s = (oldest + live) % DEPTH;
                ring[s] = '0;
                ring[s].stamp = i_stop_time;
                live = live + 1;
            end
            s = (oldest + live - 1) % DEPTH;
            if (i_command == CMD_READ) begin
                ring[s].rd = account(ring[s].rd, i_start_time, i_stop_time, i_access_size);
            end else begin
                ring[s].wr = account(ring[s].wr, i_start_time, i_stop_time, i_access_size);
            end
        end else if (i_command == CMD_READOUT) begin
            for (int k = 0; k < live; k++) begin
                expected_buckets.insert(expected_buckets.size(), ring[(oldest + k) % DEPTH]);
                expected_last.insert(expected_last.size(), k == live - 1);
            end
        end
    endtask

    task automatic compare(input string field, input logic [63:0] exp_v, input logic [63:0] act_v);
        if (exp_v !== act_v) begin
            $display("%0t: %s mismatch, expected %h, got %h", $time, field, exp_v, act_v);
            o_fail_count++;
        end
    endtask

    task automatic check_word();
        t_bucket b;
        logic    last;
        if (expected_buckets.size() == 0) begin
            $display("%0t: unexpected output word, expected none, got stamp %h",
                     $time, i_bucket_timestamp);
            o_fail_count++;
        end else begin
            b = expected_buckets[0];
            expected_buckets.delete(0);
            last = expected_last[0];
            expected_last.delete(0);
            compare("bucket_timestamp", 64'(b.stamp), 64'(i_bucket_timestamp));
            compare("read_count", 64'(b.rd.count), 64'(i_read_count));
            compare("read_sum_time", b.rd.dur_total, i_read_sum_time);
            compare("read_max_time", 64'(b.rd.dur_peak), 64'(i_read_max_time));
            compare("read_sum_size", b.rd.byte_total, i_read_sum_size);
            compare("write_count", 64'(b.wr.count), 64'(i_write_count));
            compare("write_sum_time", b.wr.dur_total, i_write_sum_time);
            compare("write_max_time", 64'(b.wr.dur_peak), 64'(i_write_max_time));
            compare("write_sum_size", b.wr.byte_total, i_write_sum_size);
            compare("last_bucket", 64'(last), 64'(i_last_bucket));
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < DEPTH; k++) begin
                ring[k] = '0;
            end
            oldest = 0;
            live = 1;
            interval_us = INTERVAL_RESET;
            limit_reg = LIMIT_RESET;
            o_fail_count = 0;
            expected_buckets.delete();
            expected_last.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_INTERVAL: interval_us = i_cfg_data;
                    CFG_LIMIT: limit_reg = i_cfg_data[4:0];
                    default: ;
                endcase
            end
            if (i_out_valid && !i_stall_out) begin
                check_word();
            end
            if (i_valid && !i_stall_in) begin
                apply_word();
            end
        end
        o_pending = expected_buckets.size();
    end

endmodule
`default_nettype wire

// ===== verif/interval_bucketed_io_stats_core_test.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Bucketed I/O statistics testbench
// Drives directed and random record, readout and no-op words into the core
// under several register settings, with random idle gaps on the input and
// random stalls on the output, and reports the verdict of the checker.
// ----------------------------------------------------------------------------
module interval_bucketed_io_stats_core_test;
    import ibios_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int  DEPTH = 16;
    localparam int  CYCLE_LIMIT = 300000;
    localparam logic [47:0] MAX48 = {48{1'b1}};

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [0:0]  i_cfg_index = CFG_INTERVAL;
    logic [47:0] i_cfg_data = '0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic [1:0]  i_command = CMD_READ;
    logic [47:0] i_start_time = '0;
    logic [47:0] i_stop_time = '0;
    logic [31:0] i_access_size = '0;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic [47:0] o_bucket_timestamp;
    logic [31:0] o_read_count;
    logic signed [63:0] o_read_sum_time;
    logic [47:0] o_read_max_time;
    logic [63:0] o_read_sum_size;
    logic [31:0] o_write_count;
    logic signed [63:0] o_write_sum_time;
    logic [47:0] o_write_max_time;
    logic [63:0] o_write_sum_size;
    logic        o_last_bucket;

    int          fail_count;
    int          pending_words;
    int          cycle_count = 0;
    int          send_idle_pct = 0;
    int          recv_stall_pct = 0;
    logic        hold_output = 1'b0;
    logic [47:0] now_us = '0;
    logic [47:0] interval_now = INTERVAL_RESET;

    interval_bucketed_io_stats_core #(.DEPTH(DEPTH)) i_dut (.*);

    interval_bucketed_io_stats_core_checker #(.DEPTH(DEPTH)) i_checker (
        .i_clk, .i_rst_n, .i_cfg_we, .i_cfg_index, .i_cfg_data, .i_valid,
        .i_stall_in(o_stall), .i_command, .i_start_time, .i_stop_time, .i_access_size,
        .i_out_valid(o_valid), .i_stall_out(i_stall), .i_bucket_timestamp(o_bucket_timestamp),
        .i_read_count(o_read_count), .i_read_sum_time(o_read_sum_time),
        .i_read_max_time(o_read_max_time), .i_read_sum_size(o_read_sum_size),
        .i_write_count(o_write_count), .i_write_sum_time(o_write_sum_time),
        .i_write_max_time(o_write_max_time), .i_write_sum_size(o_write_sum_size),
        .i_last_bucket(o_last_bucket), .o_fail_count(fail_count), .o_pending(pending_words)
    );

    always #1 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("interval_bucketed_io_stats_core test failed");
            $finish;
        end
    end

    always @(negedge i_clk) begin
        i_stall = hold_output || ($urandom_range(99) < recv_stall_pct);
    end

    task automatic send_word(input logic [1:0] cmd, input logic [47:0] start,
                             input logic [47:0] stop, input logic [31:0] size);
        while ($urandom_range(99) < send_idle_pct) begin
            @(negedge i_clk);
        end
        i_valid = 1'b1;
        i_command = cmd;
        i_start_time = start;
        i_stop_time = stop;
        i_access_size = size;
        while (o_stall) begin
            @(negedge i_clk);
        end
        @(negedge i_clk);
        i_valid = 1'b0;
    endtask

    task automatic drain();
        while (pending_words != 0) begin
            @(negedge i_clk);
        end
        repeat (16) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [0:0] index, input logic [47:0] data);
        i_cfg_we = 1'b1;
        i_cfg_index = index;
        i_cfg_data = data;
        if (index == CFG_INTERVAL) begin
            interval_now = data;
        end
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    task automatic random_word();
        int          pick;
        logic [47:0] stop;
        logic [47:0] start;
        logic [1:0]  cmd;
        pick = $urandom_range(99);
        cmd = $urandom_range(1) ? CMD_WRITE : CMD_READ;
        if (pick < 10) begin
            send_word(CMD_READOUT, 48'({$urandom, $urandom}), 48'({$urandom, $urandom}),
                      $urandom);
        end else if (pick < 12) begin
            send_word(CMD_NONE, 48'({$urandom, $urandom}), 48'({$urandom, $urandom}),
                      $urandom);
        end else begin
            now_us = now_us + 48'($urandom_range(0, 3 * int'(interval_now) + 2));
            stop = (pick < 17) ? now_us - 48'($urandom_range(0, 200)) : now_us;
            if (pick < 25) begin
                start = 48'({$urandom, $urandom});
            end else if (pick < 35) begin
                start = stop + 48'($urandom_range(1, 500));
            end else begin
                start = stop - 48'($urandom_range(0, 500));
            end
            send_word(cmd, start, stop, $urandom);
        end
    endtask

    initial begin
        repeat (5) @(negedge i_clk);
        i_rst_n = 1'b1;

        send_word(CMD_READOUT, '0, '0, '0);
        send_word(CMD_READ, 48'd0, 48'd0, 32'd0);
        send_word(CMD_WRITE, MAX48, 48'd5, {32{1'b1}});
        send_word(CMD_WRITE, 48'd100, 48'd100, 32'd1);
        send_word(CMD_READ, 48'd10, 48'd900000, {32{1'b1}});
        send_word(CMD_NONE, MAX48, MAX48, {32{1'b1}});
        send_word(CMD_READ, 48'd0, 48'd1000001, 32'd7);
        send_word(CMD_WRITE, 48'd1000001, 48'd0, 32'd9);
        send_word(CMD_READOUT, '0, '0, '0);
        drain();
        write_reg(CFG_INTERVAL, MAX48);
        write_reg(CFG_LIMIT, 48'd0);
        send_word(CMD_READ, 48'd0, 48'd5000000, 32'd3);
        send_word(CMD_READOUT, '0, '0, '0);
        now_us = 48'd2000000;

        drain();
        write_reg(CFG_INTERVAL, 48'd40);
        write_reg(CFG_LIMIT, 48'd31);
        send_idle_pct = 26;
        recv_stall_pct = 78;
        repeat (50) random_word();

        drain();
        write_reg(CFG_INTERVAL, 48'd0);
        write_reg(CFG_LIMIT, 48'd3);
        send_idle_pct = 78;
        recv_stall_pct = 26;
        repeat (45) random_word();

        drain();
        write_reg(CFG_INTERVAL, 48'd25);
        write_reg(CFG_LIMIT, 48'd16);
        send_idle_pct = 0;
        recv_stall_pct = 0;
        fork
            begin
                hold_output = 1'b1;
                repeat (300) @(negedge i_clk);
                hold_output = 1'b0;
            end
        join_none
        repeat (6) send_word(CMD_READOUT, '0, '0, '0);
        repeat (40) random_word();
        drain();
        write_reg(CFG_LIMIT, 48'd1);
        repeat (8) random_word();
        send_word(CMD_READ, 48'd0, MAX48, 32'd1);
        send_word(CMD_READOUT, '0, '0, '0);

        drain();
        if (fail_count == 0) begin
            $display("interval_bucketed_io_stats_core test passed");
        end else begin
            $display("interval_bucketed_io_stats_core test failed");
        end
        $finish;
    end

endmodule
`default_nettype wire

// ===== interval_bucketed_io_stats_core.f =====
design/ibios_pkg.sv
design/ibios_update.sv
design/interval_bucketed_io_stats_core.sv
verif/interval_bucketed_io_stats_core_checker.sv
verif/interval_bucketed_io_stats_core_test.sv
